[sv/dbd_pkg.sv]
`default_nettype none
package dbd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DATE_W  = YEAR_W + MONTH_W + DAY_W;
    localparam int IN_W    = 2 * DATE_W;
    localparam int S_DATA_W = ((IN_W + 7) / 8) * 8;
    localparam int COUNT_W = 22;
    localparam int M_DATA_W = ((COUNT_W + 7) / 8) * 8;
    localparam int ORD_W   = 23;
    localparam int P_W     = 15;

    // p / 100 == (p * RECIP_100) >> RECIP_SHIFT for p < 2**15
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam logic [P_W-1:0] YEAR_OFFSET = 15'd399;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic load_in;
        logic sel_end;
        logic step1;
        logic step2;
        logic step3;
        logic load_out;
    } dbd_cmd_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            default:   len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] n;
        case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

[sv/dbd_ctrl.sv]
`default_nettype none
module dbd_ctrl
    import dbd_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  wire        m_tready,
    output dbd_cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_A1   = 3'd1;
    localparam logic [2:0] ST_A2   = 3'd2;
    localparam logic [2:0] ST_A3   = 3'd3;
    localparam logic [2:0] ST_B1   = 3'd4;
    localparam logic [2:0] ST_B2   = 3'd5;
    localparam logic [2:0] ST_B3   = 3'd6;
    localparam logic [2:0] ST_FIN  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       valid_reg, valid_next;
    logic       out_free;

    assign out_free = !valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next = ST_A1;
                end
            end
            ST_A1: begin
                cmd.step1 = 1'b1;
                state_next = ST_A2;
            end
            ST_A2: begin
                cmd.step2 = 1'b1;
                state_next = ST_A3;
            end
            ST_A3: begin
                cmd.step3 = 1'b1;
                state_next = ST_B1;
            end
            ST_B1: begin
                cmd.sel_end = 1'b1;
                cmd.step1 = 1'b1;
                state_next = ST_B2;
            end
            ST_B2: begin
                cmd.sel_end = 1'b1;
                cmd.step2 = 1'b1;
                state_next = ST_B3;
            end
            ST_B3: begin
                cmd.sel_end = 1'b1;
                cmd.step3 = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule
`default_nettype wire

[sv/dbd_datapath.sv]
`default_nettype none
module dbd_datapath
    import dbd_pkg::*;
(
    input  wire                  aclk,
    input  wire [IN_W-1:0]       in_data,
    input  dbd_cmd_t             cmd,
    output logic [COUNT_W-1:0]   day_count,
    output logic                 end_not_later
);

    logic [IN_W-1:0]    in_reg;
    logic [YEAR_W-1:0]  y_reg;
    logic [MONTH_W-1:0] m_reg;
    logic [DAY_W-1:0]   d_reg;
    logic [P_W-1:0]     p_reg;
    logic [P_W+RECIP_W-1:0]    prodp_reg;
    logic [YEAR_W+RECIP_W-1:0] prody_reg;
    logic               leap_reg, leap_next;
    logic [ORD_W-1:0]   base_reg, base_next;
    logic [ORD_W-1:0]   ord_a_reg, ord_b_reg, ord_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               flag_reg, flag_next;

    logic [YEAR_W-1:0]  y_sel;
    logic [MONTH_W-1:0] m_sel;
    logic [DAY_W-1:0]   d_sel;
    logic [P_W-1:0]     p_next;
    logic [8:0]         q100p;
    logic [7:0]         q100y;
    logic [YEAR_W-1:0]  r100;
    logic [MONTH_W-1:0] m_fix;
    logic [DAY_W-1:0]   len, d_fix;
    logic [ORD_W-1:0]   diff;

    // date fields: year, month, day from the low bits up
    always_comb begin
        if (cmd.sel_end) begin
            y_sel = in_reg[DATE_W +: YEAR_W];
            m_sel = in_reg[DATE_W+YEAR_W +: MONTH_W];
            d_sel = in_reg[DATE_W+YEAR_W+MONTH_W +: DAY_W];
        end else begin
            y_sel = in_reg[0 +: YEAR_W];
            m_sel = in_reg[YEAR_W +: MONTH_W];
            d_sel = in_reg[YEAR_W+MONTH_W +: DAY_W];
        end
    end

    assign p_next = P_W'(y_sel) + YEAR_OFFSET;

    // step 2: century quotients, leap flag, year part of the ordinal
    assign q100p = prodp_reg[RECIP_SHIFT +: 9];
    assign q100y = prody_reg[RECIP_SHIFT +: 8];
    assign r100  = y_reg - YEAR_W'(q100y) * YEAR_W'(100);

    always_comb begin
        leap_next = (y_reg[1:0] == 2'd0) && ((r100 != '0) || (q100y[1:0] == 2'd0));
        base_next = ORD_W'(p_reg) * ORD_W'(365) + ORD_W'(p_reg[P_W-1:2])
                  + ORD_W'(q100p[8:2]) - ORD_W'(q100p);
    end

    // step 3: clamp month and day, add month and day part
    always_comb begin
        if (m_reg < MONTH_JAN) begin
            m_fix = MONTH_JAN;
        end else if (m_reg > MONTH_DEC) begin
            m_fix = MONTH_DEC;
        end else begin
            m_fix = m_reg;
        end
        len = month_len(m_fix, leap_reg);
        if (d_reg == '0) begin
            d_fix = 5'd1;
        end else if (d_reg > len) begin
            d_fix = len;
        end else begin
            d_fix = d_reg;
        end
        ord_next = base_reg + ORD_W'(days_before(m_fix))
                 + ORD_W'((m_fix > MONTH_FEB) && leap_reg) + ORD_W'(d_fix);
    end

    always_comb begin
        diff = ord_b_reg - ord_a_reg;
        if (ord_a_reg < ord_b_reg) begin
            flag_next = 1'b0;
            count_next = diff[ORD_W-1] ? {COUNT_W{1'b1}} : diff[COUNT_W-1:0];
        end else begin
            flag_next = 1'b1;
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= in_data;
        end
        if (cmd.step1) begin
            y_reg     <= y_sel;
            m_reg     <= m_sel;
            d_reg     <= d_sel;
            p_reg     <= p_next;
            prodp_reg <= (P_W+RECIP_W)'(p_next) * (P_W+RECIP_W)'(RECIP_100);
            prody_reg <= (YEAR_W+RECIP_W)'(y_sel) * (YEAR_W+RECIP_W)'(RECIP_100);
        end
        if (cmd.step2) begin
            leap_reg <= leap_next;
            base_reg <= base_next;
        end
        if (cmd.step3) begin
            if (cmd.sel_end) begin
                ord_b_reg <= ord_next;
            end else begin
                ord_a_reg <= ord_next;
            end
        end
        if (cmd.load_out) begin
            count_reg <= count_next;
            flag_reg  <= flag_next;
        end
    end

    assign day_count     = count_reg;
    assign end_not_later = flag_reg;

endmodule
`default_nettype wire

[sv/days_between_dates_top.sv]
`default_nettype none
// Days between two Gregorian dates. Each request holds a start and an end date; the
// block turns each into a day ordinal in closed form and returns the difference, or
// zero with end_not_later set when the end is not after the start. Out-of-range months
// and days are clamped; counts above 22 bits saturate. One request is handled at a
// time: the three-step ordinal unit is run once for each date, then the final compare
// loads the output register. The next request is accepted the cycle after a result
// enters the output register, even while that result still waits.
module days_between_dates_top
    import dbd_pkg::*;
(
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    // start_year, start_month, start_day, end_year, end_month, end_day, zero pad
    input  wire [S_DATA_W-1:0]   s_tdata,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    // day_count, zero pad
    output logic [M_DATA_W-1:0]  m_tdata,
    // end_not_later
    output logic                 m_tuser
);

    dbd_cmd_t           cmd;
    logic [COUNT_W-1:0] day_count;

    dbd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    dbd_datapath u_dp (
        .aclk          (aclk),
        .in_data       (s_tdata[IN_W-1:0]),
        .cmd           (cmd),
        .day_count     (day_count),
        .end_not_later (m_tuser)
    );

    assign m_tdata = M_DATA_W'(day_count);

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in progress");

    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("nonzero count with end_not_later set");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata != '0))
        else $error("zero count without end_not_later");

endmodule
`default_nettype wire
